FILE: hw/rtl/range_max_segment_tree_macros.svh
// Assertion macros of the range-maximum tree checker.
`ifndef RANGE_MAX_SEGMENT_TREE_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_MACROS_SVH

// Check a property on the rising clock, skipped while reset is held.
`define RMST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, reset included.
`define RMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rmst_pkg.sv
// Shared constants, codes and types of the range-maximum segment tree.
package rmst_pkg;

    localparam int DEF_MAX_ELEMS  = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int KIND_W = 2;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int CNT_LIMIT = (2 ** CNT_W) - 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_WIN_R = 2'd1,
        KIND_WIN_L = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    // Work handed to the tree walker.
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] last;
    } t_cmd;

    // Completion report from the tree walker.
    typedef struct packed {
        logic done;
        logic result;
    } t_rsp;

endpackage

FILE: hw/rtl/rmst_mem.sv
// Node storage of the tree: one write port, one read port with registered data.
module rmst_mem
    import rmst_pkg::*;
#(
    parameter int DEPTH      = 4 * DEF_MAX_ELEMS,
    parameter int ADDR_W     = $clog2(4 * DEF_MAX_ELEMS),
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic signed [DATA_WIDTH-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic signed [DATA_WIDTH-1:0] o_rdata
);

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rmst_walker.sv
// Sequencer that walks the tree for point updates and range reads.
module rmst_walker
    import rmst_pkg::*;
#(
    parameter int MAX_ELEMS  = DEF_MAX_ELEMS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  t_cmd                         i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output t_rsp                         o_rsp,
    output logic signed [DATA_WIDTH-1:0] o_max
);

    localparam int DEPTH  = 4 * MAX_ELEMS;
    localparam int NODE_W = $clog2(DEPTH);
    localparam int STK_D  = $clog2(MAX_ELEMS) + 2;
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam int SI_W   = $clog2(STK_D);
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WDESC  = 5'b00010,
        ST_WASC   = 5'b00100,
        ST_QWALK  = 5'b01000,
        ST_QDRAIN = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [NODE_W-1:0] r_node, n_node;
    logic [CNT_W-1:0]  r_s, n_s, r_e, n_e;
    logic [CNT_W-1:0]  r_idx, r_lo, r_hi;
    logic signed [DATA_WIDTH-1:0] r_val, n_val, r_acc, n_acc;
    logic              r_rd_pend, n_rd_pend;
    logic [SP_W-1:0]   r_sp, n_sp;

    logic [NODE_W-1:0] r_stk_node [STK_D];
    logic [CNT_W-1:0]  r_stk_s [STK_D];
    logic [CNT_W-1:0]  r_stk_e [STK_D];

    logic              w_push;
    logic [SP_W-1:0]   w_top;
    logic [CNT_W-1:0]  w_mid;
    logic [NODE_W-1:0] w_lchild, w_rchild, w_parent, w_sibling, w_par_sib;
    logic              w_covered, w_disjoint;
    logic signed [DATA_WIDTH-1:0] w_up;

    logic                         w_we, w_re;
    logic [NODE_W-1:0]            w_waddr, w_raddr;
    logic signed [DATA_WIDTH-1:0] w_wdata, w_rdata;

    rmst_mem #(
        .DEPTH      (DEPTH),
        .ADDR_W     (NODE_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_mid      = r_s + ((r_e - r_s) >> 1);
    assign w_lchild   = (r_node << 1) | NODE_W'(1);
    assign w_rchild   = (r_node << 1) + NODE_W'(2);
    assign w_parent   = (r_node - NODE_W'(1)) >> 1;
    assign w_sibling  = r_node[0] ? r_node + NODE_W'(1) : r_node - NODE_W'(1);
    assign w_par_sib  = w_parent[0] ? w_parent + NODE_W'(1) : w_parent - NODE_W'(1);
    assign w_covered  = (r_lo <= r_s) && (r_hi >= r_e);
    assign w_disjoint = (r_e < r_lo) || (r_s > r_hi);
    assign w_top      = r_sp - SP_W'(1);
    assign w_up       = (w_rdata > r_val) ? w_rdata : r_val;

    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_s       = r_s;
        n_e       = r_e;
        n_val     = r_val;
        n_sp      = r_sp;
        n_rd_pend = 1'b0;
        n_acc     = (r_rd_pend && (w_rdata > r_acc)) ? w_rdata : r_acc;
        w_push    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_node;
        w_wdata   = r_val;
        w_re      = 1'b0;
        w_raddr   = w_sibling;
        o_rsp     = '0;
        case (r_state)
            ST_IDLE: begin
                n_acc = VAL_MIN;
                if (i_start) begin
                    n_node  = '0;
                    n_s     = '0;
                    n_e     = i_cmd.last;
                    n_val   = i_value;
                    n_sp    = '0;
                    n_state = i_cmd.load ? ST_WDESC : ST_QWALK;
                end
            end
            ST_WDESC: begin
                if (r_s == r_e) begin
                    // Store the leaf, fetch its sibling for the climb.
                    w_we = 1'b1;
                    if (r_node == '0) begin
                        o_rsp.done = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        w_re    = 1'b1;
                        n_state = ST_WASC;
                    end
                end else if (r_idx <= w_mid) begin
                    n_node = w_lchild;
                    n_e    = w_mid;
                end else begin
                    n_node = w_rchild;
                    n_s    = w_mid + CNT_W'(1);
                end
            end
            ST_WASC: begin
                // Merge with the sibling, write the parent, prefetch the next sibling.
                w_we    = 1'b1;
                w_waddr = w_parent;
                w_wdata = w_up;
                n_val   = w_up;
                n_node  = w_parent;
                if (w_parent == '0) begin
                    o_rsp.done = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_par_sib;
                end
            end
            ST_QWALK: begin
                if (w_covered || w_disjoint) begin
                    if (w_covered) begin
                        w_re      = 1'b1;
                        w_raddr   = r_node;
                        n_rd_pend = 1'b1;
                    end
                    if (r_sp == '0) begin
                        n_state = ST_QDRAIN;
                    end else begin
                        n_node = r_stk_node[w_top[SI_W-1:0]];
                        n_s    = r_stk_s[w_top[SI_W-1:0]];
                        n_e    = r_stk_e[w_top[SI_W-1:0]];
                        n_sp   = w_top;
                    end
                end else begin
                    // Defer the right half, go left.
                    w_push = 1'b1;
                    n_sp   = r_sp + SP_W'(1);
                    n_node = w_lchild;
                    n_e    = w_mid;
                end
            end
            ST_QDRAIN: begin
                o_rsp.done   = 1'b1;
                o_rsp.result = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_max = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_s    <= n_s;
        r_e    <= n_e;
        r_val  <= n_val;
        r_acc  <= n_acc;
        if (r_state == ST_IDLE && i_start) begin
            r_idx <= i_cmd.idx;
            r_lo  <= i_cmd.lo;
            r_hi  <= i_cmd.hi;
        end
        if (w_push) begin
            r_stk_node[r_sp[SI_W-1:0]] <= w_rchild;
            r_stk_s[r_sp[SI_W-1:0]]    <= w_mid + CNT_W'(1);
            r_stk_e[r_sp[SI_W-1:0]]    <= r_e;
        end
    end

endmodule

FILE: hw/rtl/range_max_segment_tree.sv
// Range-maximum segment tree: top level with handshake, window and count register.
//
// Input channel: i_in_valid / o_in_stall carry one item (kind, element index and
// value, query range). Kind load writes one element, kind window-right and
// window-left move an end of the sliding window by one, kind query reads the
// inclusive range clipped to the element count. Each non-load item gives one
// result on o_out_valid / i_out_stall: the signed maximum, or the most negative
// value with o_out_range_empty set when the range holds nothing.
// i_cfg_we / i_cfg_wdata set the element count (0 reads as 1, big values clamp).
// Rate: one item at a time. A load descends from the root to the leaf, then climbs
// back up one level at a time, writing each parent. A query walks the covered
// and split nodes with a stack for the deferred right halves; an empty range or an
// ignored load starts no walk. The single read port of the node memory sets the pace.
// Reset clears the window to empty and the count to its maximum; node storage
// holds garbage until loaded. A stalled result holds in the output register;
// input stalls while a result waits stalled or a walk is in progress.
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int MAX_ELEMS  = DEF_MAX_ELEMS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [KIND_W-1:0]            i_in_kind,
    input  logic [IDX_W-1:0]             i_in_elem_index,
    input  logic signed [DATA_WIDTH-1:0] i_in_elem_value,
    input  logic [IDX_W-1:0]             i_in_range_lo,
    input  logic [IDX_W-1:0]             i_in_range_hi,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_out_max_value,
    output logic                         o_out_range_empty,
    input  logic                         i_cfg_we,
    input  logic [CNT_W-1:0]             i_cfg_wdata
);

    // Largest count the register can hold for this size.
    localparam int CNT_MAX = (MAX_ELEMS > CNT_LIMIT) ? CNT_LIMIT : MAX_ELEMS;
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_win_left, n_win_left;
    logic [CNT_W-1:0] r_win_rnext, n_win_rnext;
    logic             r_busy, n_busy;
    logic             r_out_valid, n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_max;
    logic             r_out_empty;

    logic             w_accept;
    logic             w_is_load, w_load_ok;
    logic [CNT_W-1:0] w_lo, w_hi_raw, w_hi;
    logic             w_hi_ok, w_empty;
    logic             w_start;
    t_cmd             w_cmd;
    t_rsp             w_rsp;
    logic signed [DATA_WIDTH-1:0] w_walk_max;

    // Stall while walking or while a finished result is held up.
    assign o_in_stall = r_busy | (r_out_valid & i_out_stall);
    assign w_accept   = i_in_valid & ~o_in_stall;

    // Advance the window ends, saturating at the count; window kinds read the new window.
    always_comb begin
        n_win_left  = r_win_left;
        n_win_rnext = r_win_rnext;
        w_is_load   = 1'b0;
        w_lo        = {1'b0, i_in_range_lo};
        w_hi_raw    = {1'b0, i_in_range_hi};
        w_hi_ok     = 1'b1;
        case (t_kind'(i_in_kind))
            KIND_LOAD: begin
                w_is_load = 1'b1;
            end
            KIND_WIN_R: begin
                if (r_win_rnext < r_count) begin
                    n_win_rnext = r_win_rnext + CNT_W'(1);
                end
            end
            KIND_WIN_L: begin
                if (r_win_left < r_count) begin
                    n_win_left = r_win_left + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (i_in_kind == KIND_WIN_R || i_in_kind == KIND_WIN_L) begin
            w_lo     = n_win_left;
            w_hi_raw = n_win_rnext - CNT_W'(1);
            w_hi_ok  = (n_win_rnext != '0);
        end
    end

    // Clip the upper end to the last element; decide emptiness here.
    assign w_hi      = (w_hi_raw >= r_count) ? r_count - CNT_W'(1) : w_hi_raw;
    assign w_empty   = ~w_hi_ok | (w_lo > w_hi);
    assign w_load_ok = ({1'b0, i_in_elem_index} < r_count);
    assign w_start   = w_accept & (w_is_load ? w_load_ok : ~w_empty);

    assign w_cmd.load = w_is_load;
    assign w_cmd.idx  = {1'b0, i_in_elem_index};
    assign w_cmd.lo   = w_lo;
    assign w_cmd.hi   = w_hi;
    assign w_cmd.last = r_count - CNT_W'(1);

    rmst_walker #(
        .MAX_ELEMS  (MAX_ELEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cmd   (w_cmd),
        .i_value (i_in_elem_value),
        .o_rsp   (w_rsp),
        .o_max   (w_walk_max)
    );

    // Clamp the written count into one to the maximum.
    always_comb begin
        n_count = r_count;
        if (i_cfg_we) begin
            if (i_cfg_wdata == '0) begin
                n_count = CNT_W'(1);
            end else if (32'(i_cfg_wdata) > CNT_MAX) begin
                n_count = CNT_W'(CNT_MAX);
            end else begin
                n_count = i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (w_start) begin
            n_busy = 1'b1;
        end else if (w_rsp.done) begin
            n_busy = 1'b0;
        end
    end

    // Hold a stalled result; load a new one from the walker or an empty range.
    assign n_out_valid = (r_out_valid & i_out_stall)
                       | (w_rsp.done & w_rsp.result)
                       | (w_accept & ~w_is_load & w_empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(CNT_MAX);
            r_win_left  <= '0;
            r_win_rnext <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_win_left  <= n_win_left;
                r_win_rnext <= n_win_rnext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.done && w_rsp.result) begin
            r_out_max   <= w_walk_max;
            r_out_empty <= 1'b0;
        end else if (w_accept && !w_is_load && w_empty) begin
            r_out_max   <= VAL_MIN;
            r_out_empty <= 1'b1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_max_value   = r_out_max;
    assign o_out_range_empty = r_out_empty;

endmodule

FILE: hw/rtl/rmst_checker.sv
// Port-level checks of the range-maximum tree, bound to the top level.
`include "range_max_segment_tree_macros.svh"

module rmst_checker
    import rmst_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [DATA_WIDTH-1:0] o_out_max_value,
    input logic                         o_out_range_empty
);

    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    `RMST_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_max_value) && $stable(o_out_range_empty), "stalled result changed")
    `RMST_ASSERT(a_empty_min, i_clk, i_rst_n, o_out_valid && o_out_range_empty |-> o_out_max_value == VAL_MIN, "empty range without most negative value")
    `RMST_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid, "result present after reset")
    `RMST_ASSERT(a_result_cause, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall) || $past(i_in_valid), "result without an item")

endmodule

bind range_max_segment_tree rmst_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rmst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_out_max_value   (o_out_max_value),
    .o_out_range_empty (o_out_range_empty)
);

FILE: tb/range_max_tracker_pkg.sv
// Expected-result tracker for the range-maximum segment tree: shadow tree, window and count.
`timescale 1ns / 1ps

package range_max_tracker_pkg;
    import rmst_pkg::*;

    localparam int DW    = DEF_DATA_WIDTH;
    localparam int ELEMS = DEF_MAX_ELEMS;
    localparam int SLOTS = 4 * ELEMS;

    localparam logic [DW-1:0] SIGN_FLIP = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] index;
        logic [DW-1:0]    value;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_tree_item;

    typedef struct packed {
        logic [DW-1:0] max_value;
        logic          empty;
    } t_answer;

    class range_max_tracker;
        // node maxima held with the sign bit flipped, so unsigned order is signed order
        logic [DW-1:0] node_key [SLOTS];
        // set once a node holds a value built only from loaded leaves
        bit            node_known [SLOTS];
        int unsigned   elem_count;
        int unsigned   win_left;
        int unsigned   win_right_next;
        t_answer       expected_maxima [$];
        int unsigned   mismatches;

        function new();
            foreach (node_key[i]) begin
                node_key[i]   = SIGN_FLIP;
                node_known[i] = 1'b0;
            end
            elem_count     = ELEMS;
            win_left       = 0;
            win_right_next = 0;
            mismatches     = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            if (v == 0) begin
                elem_count = 1;
            end else if (v > ELEMS) begin
                elem_count = ELEMS;
            end else begin
                elem_count = v;
            end
        endfunction

        // Range an item reads after clipping, and the window it leaves behind.
        function void resolve(input t_tree_item it, output int unsigned lo,
                              output int unsigned hi, output bit empty,
                              output int unsigned nl, output int unsigned nr);
            bit hi_ok;
            nl    = win_left;
            nr    = win_right_next;
            hi_ok = 1'b1;
            if (it.kind == KIND_WIN_R || it.kind == KIND_WIN_L) begin
                if (it.kind == KIND_WIN_R && nr < elem_count) nr++;
                if (it.kind == KIND_WIN_L && nl < elem_count) nl++;
                lo    = nl;
                hi_ok = (nr != 0);
                hi    = hi_ok ? nr - 1 : 0;
            end else begin
                lo = it.lo;
                hi = it.hi;
            end
            if (hi_ok && hi >= elem_count) hi = elem_count - 1;
            empty = !hi_ok || lo > hi;
        endfunction

        function void store_leaf(int unsigned node, int unsigned s, int unsigned e,
                                 int unsigned idx, logic [DW-1:0] key);
            int unsigned m;
            if (node >= SLOTS) return;
            if (s == e) begin
                node_key[node]   = key;
                node_known[node] = 1'b1;
                return;
            end
            m = s + (e - s) / 2;
            if (idx <= m) store_leaf(2 * node + 1, s, m, idx, key);
            else          store_leaf(2 * node + 2, m + 1, e, idx, key);
            if (2 * node + 2 < SLOTS) begin
                node_key[node] = (node_key[2 * node + 1] > node_key[2 * node + 2]) ?
                                 node_key[2 * node + 1] : node_key[2 * node + 2];
                node_known[node] = node_known[2 * node + 1] && node_known[2 * node + 2];
            end
        endfunction

        function logic [DW-1:0] span_max(int unsigned node, int unsigned s, int unsigned e,
                                         int unsigned lo, int unsigned hi);
            int unsigned   m;
            logic [DW-1:0] left_key;
            logic [DW-1:0] right_key;
            if (node >= SLOTS) return '0;
            if (lo <= s && hi >= e) return node_key[node];
            if (e < lo || s > hi) return '0;
            m         = s + (e - s) / 2;
            left_key  = span_max(2 * node + 1, s, m, lo, hi);
            right_key = span_max(2 * node + 2, m + 1, e, lo, hi);
            return (left_key > right_key) ? left_key : right_key;
        endfunction

        // Same walk as span_max: true when every node it reads is known.
        function bit span_known(int unsigned node, int unsigned s, int unsigned e,
                                int unsigned lo, int unsigned hi);
            int unsigned m;
            if (node >= SLOTS) return 1'b1;
            if (lo <= s && hi >= e) return node_known[node];
            if (e < lo || s > hi) return 1'b1;
            m = s + (e - s) / 2;
            return span_known(2 * node + 1, s, m, lo, hi) &&
                   span_known(2 * node + 2, m + 1, e, lo, hi);
        endfunction

        function bit reads_defined(t_tree_item it);
            int unsigned lo, hi, nl, nr;
            bit          empty;
            if (it.kind == KIND_LOAD) return 1'b1;
            resolve(it, lo, hi, empty, nl, nr);
            return empty || span_known(0, 0, elem_count - 1, lo, hi);
        endfunction

        function bit ignores(t_tree_item it);
            return it.kind == KIND_LOAD && it.index >= elem_count;
        endfunction

        function void note_item(t_tree_item it);
            int unsigned   lo, hi, nl, nr;
            bit            empty;
            logic [DW-1:0] key;
            if (it.kind == KIND_LOAD) begin
                if (it.index < elem_count)
                    store_leaf(0, 0, elem_count - 1, it.index, it.value ^ SIGN_FLIP);
                return;
            end
            resolve(it, lo, hi, empty, nl, nr);
            win_left       = nl;
            win_right_next = nr;
            key = empty ? '0 : span_max(0, 0, elem_count - 1, lo, hi);
            expected_maxima.push_back('{max_value: key ^ SIGN_FLIP, empty: empty});
        endfunction

        function void check_answer(logic [DW-1:0] max_value, logic empty);
            t_answer want;
            if (expected_maxima.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: max_value %0d range_empty %0b",
                         $time, $signed(max_value), empty);
                return;
            end
            want = expected_maxima.pop_front();
            if (max_value !== want.max_value) begin
                mismatches++;
                $display("%0t: max_value mismatch: expected %0d, actual %0d",
                         $time, $signed(want.max_value), $signed(max_value));
            end
            if (empty !== want.empty) begin
                mismatches++;
                $display("%0t: range_empty mismatch: expected %0b, actual %0b",
                         $time, want.empty, empty);
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_range_max_segment_tree.sv
// Top-level testbench of the range-maximum segment tree: stimulus, idling and checking.
`timescale 1ns / 1ps

module tb_range_max_segment_tree;
    import rmst_pkg::*;
    import range_max_tracker_pkg::*;

    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MOST_POS = ~MOST_NEG;

    localparam int SETTLE_CYCLES  = 64;
    localparam int END_CYCLES     = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 26;
    localparam int NUM_PHASES     = 12;
    localparam int STALE_PHASE    = 7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     in_kind = '0;
    logic [IDX_W-1:0]      in_elem_index = '0;
    logic signed [DW-1:0]  in_elem_value = '0;
    logic [IDX_W-1:0]      in_range_lo = '0;
    logic [IDX_W-1:0]      in_range_hi = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [DW-1:0]  out_max_value;
    logic                  out_range_empty;
    logic                  cfg_we = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;

    range_max_tracker tracker;

    int burst_left = 0;
    int hold_requests = 0;
    int rx_seen_holds = 0;
    int rx_pct = 0;
    int rx_span = 0;
    int idle_cycles = 0;
    int sent = 0;

    // Counts per phase: small trees, both extremes, and the clamped codes 0 and 2047.
    int unsigned phase_counts [NUM_PHASES] =
        '{5, 1024, 1, 37, 1023, 2, 64, 12, 300, 2047, 0, 17};

    t_tree_item next_item;

    range_max_segment_tree #(
        .MAX_ELEMS  (ELEMS),
        .DATA_WIDTH (DW)
    ) i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_in_kind         (in_kind),
        .i_in_elem_index   (in_elem_index),
        .i_in_elem_value   (in_elem_value),
        .i_in_range_lo     (in_range_lo),
        .i_in_range_hi     (in_range_hi),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_out_max_value   (out_max_value),
        .o_out_range_empty (out_range_empty),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_tree_item make_item(t_kind kind, int unsigned index,
                                             logic [DW-1:0] value,
                                             int unsigned lo, int unsigned hi);
        t_tree_item it;
        it.kind  = kind;
        it.index = IDX_W'(index);
        it.value = value;
        it.lo    = IDX_W'(lo);
        it.hi    = IDX_W'(hi);
        return it;
    endfunction

    function automatic logic [DW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return '1;
            default: return DW'($urandom);
        endcase
    endfunction

    // Mostly in-range loads and reads; some loads past the count and some ranges
    // drawn over the whole 10-bit field, so they clip or come out empty.
    function automatic t_tree_item rand_item();
        t_tree_item  it;
        int unsigned top;
        int unsigned lo;
        int          pick;
        top      = tracker.elem_count - 1;
        it       = make_item(KIND_QUERY, $urandom, rand_value(), $urandom, $urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 25) begin
            it.kind = KIND_LOAD;
            if ($urandom_range(0, 4) != 0) it.index = IDX_W'($urandom_range(0, top));
        end else if (pick < 45) begin
            it.kind = KIND_WIN_R;
        end else if (pick < 60) begin
            it.kind = KIND_WIN_L;
        end else begin
            lo = $urandom_range(0, top);
            case ($urandom_range(0, 3))
                0: begin
                    it.lo = IDX_W'(lo);
                    it.hi = IDX_W'($urandom_range(lo, top));
                end
                1: it.lo = IDX_W'(lo);
                2: ;
                default: begin
                    it.lo = IDX_W'(lo);
                    it.hi = IDX_W'(lo);
                end
            endcase
        end
        return it;
    endfunction

    // Offer one item and hold it until accepted. Start at a falling edge, end at
    // the accepting rising edge, so the caller decides what the next fall drives.
    task automatic send_item(input t_tree_item it);
        t_tree_item pick;
        pick = it;
        // never touch nodes that hold garbage: swap in an always-empty query
        if (!tracker.reads_defined(pick))
            pick = make_item(KIND_QUERY, $urandom, rand_value(), IDX_W'('1), 0);
        @(negedge clk);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 40);
        end
        in_valid      <= 1'b1;
        in_kind       <= pick.kind;
        in_elem_index <= pick.index;
        in_elem_value <= pick.value;
        in_range_lo   <= pick.lo;
        in_range_hi   <= pick.hi;
        // right after the edge the stall still shows the value the block used
        do @(posedge clk); while (in_stall);
        tracker.note_item(pick);
        burst_left--;
    endtask

    // Drop valid and wait until every expected result has been taken.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_maxima.size() != 0) @(negedge clk);
    endtask

    // Write the count only with the block idle; a load may still be walking
    // after the last result, so let it finish first.
    task automatic write_count(input logic [CNT_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_count(v);
    endtask

    // Load the whole tree when small, else a prefix and a suffix of it.
    task automatic reload(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (n <= 24 || i < 12 || i >= n - 12)
                send_item(make_item(KIND_LOAD, i, rand_value(), $urandom, $urandom));
        end
    endtask

    // Receiver: stall on runs of random density; on request hold off for a long
    // stretch so the block backs up into its input.
    initial begin
        forever begin
            case ($urandom_range(0, 3))
                0: rx_pct = 0;
                1: rx_pct = 30;
                2: rx_pct = 85;
                default: rx_pct = 50;
            endcase
            rx_span = $urandom_range(8, 80);
            repeat (rx_span) begin
                @(negedge clk);
                if (hold_requests != rx_seen_holds) begin
                    rx_seen_holds = hold_requests;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end else begin
                    out_stall <= ($urandom_range(0, 99) < rx_pct);
                end
            end
        end
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_answer(out_max_value, out_range_empty);
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** range_max_segment_tree: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        tracker = new();
        // hold reset, then release it at a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: count at its reset maximum, extremes at both ends.
        send_item(make_item(KIND_LOAD, 0, MOST_NEG, 0, 0));
        send_item(make_item(KIND_LOAD, 1023, MOST_POS, 1023, 1023));
        send_item(make_item(KIND_QUERY, 0, 0, 0, 0));
        send_item(make_item(KIND_QUERY, 0, 0, 1023, 1023));
        // low end above high end: empty
        send_item(make_item(KIND_QUERY, 0, 0, 5, 2));
        // window grows to one element, then crosses and empties
        send_item(make_item(KIND_WIN_R, 0, 0, 0, 0));
        send_item(make_item(KIND_WIN_L, 0, 0, 0, 0));
        send_item(make_item(KIND_LOAD, 1, '1, 0, 0));
        send_item(make_item(KIND_LOAD, 2, '0, 0, 0));
        send_item(make_item(KIND_LOAD, 3, 1, 0, 0));
        send_item(make_item(KIND_QUERY, 0, 0, 0, 3));
        repeat (3) send_item(make_item(KIND_WIN_R, 0, 0, 0, 0));

        // Count code 0 reads as one element.
        write_count(0);
        send_item(make_item(KIND_LOAD, 0, 42, 0, 0));
        // load past the count: dropped
        send_item(make_item(KIND_LOAD, 700, MOST_POS, 0, 0));
        // high end clipped to the count
        send_item(make_item(KIND_QUERY, 0, 0, 0, 1023));
        // both window ends sit at or past the count and stay there
        send_item(make_item(KIND_WIN_R, 0, 0, 0, 0));
        send_item(make_item(KIND_WIN_L, 0, 0, 0, 0));

        // Code 2047 clamps to the maximum; the root now holds a stale maximum.
        write_count('1);
        send_item(make_item(KIND_QUERY, 0, 0, 0, 1023));

        // Random phases, one count each; one phase keeps the old tree contents.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_count(CNT_W'(phase_counts[p]));
            if (p != STALE_PHASE) reload(tracker.elem_count);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (sent == 10 && (p == 1 || p == 6)) hold_requests++;
                if (sent == 20 && p == 3) drain();
                next_item = rand_item();
                for (int t = 0; t < 10 && !tracker.reads_defined(next_item); t++)
                    next_item = rand_item();
                if (!tracker.ignores(next_item)) sent++;
                send_item(next_item);
            end
        end

        drain();
        repeat (END_CYCLES) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.expected_maxima.size() == 0) begin
            $display("** range_max_segment_tree: PASSED **");
        end else begin
            $display("** range_max_segment_tree: FAILED **");
        end
        $finish;
    end

endmodule
